FILE: design/frrb_pkg.sv
// Package for the framed receive ring buffer.
// Holds the frame marks, field widths, status codes and the controller/datapath interface types.
// No dependencies.
package frrb_pkg;

	localparam int DEFAULT_BUFFER_DEPTH = 64;
	localparam int BYTE_W = 8;
	localparam int LEN_W = 6;
	localparam int STATUS_W = 2;

	localparam logic OP_RX = 1'b0;
	localparam logic OP_POP = 1'b1;

	localparam logic [BYTE_W-1:0] START_MARK = 8'h24;
	localparam logic [BYTE_W-1:0] END_MARK = 8'h3A;

	localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_COMPLETE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_INCOMPLETE = 2'd2;

	typedef struct packed {
		logic store;
		logic clr_count;
		logic adv_rp;
		logic emit_byte;
		logic emit_close;
		logic [STATUS_W-1:0] close_status;
	} dp_cmd_t;

	typedef struct packed {
		logic ptr_equal;
		logic is_start;
		logic is_end;
	} dp_sts_t;

endpackage

FILE: design/framed_receive_ring_buffer_top.sv
// Top level of the framed receive ring buffer.
// Instantiates frrb_ctrl and frrb_datapath; depends on frrb_pkg.
//
// A received byte (operation 0) is taken while busy stays low. A pop (operation 1) holds busy
// high while the controller walks the ring one stored byte at a time, since every entry takes a
// registered memory read followed by a check. A pop ends on an end mark or when it runs into
// the write pointer. Each result is shown for one cycle under result_strobe and cannot be held
// off, with the closing transfer appearing in the first cycle after busy falls.
module framed_receive_ring_buffer_top #(
	parameter int BUFFER_DEPTH = frrb_pkg::DEFAULT_BUFFER_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [frrb_pkg::BYTE_W-1:0]   rx_byte,
	output logic                          result_strobe,
	output logic [frrb_pkg::BYTE_W-1:0]   payload_byte,
	output logic                          byte_valid,
	output logic                          last,
	output logic [frrb_pkg::STATUS_W-1:0] pop_status,
	output logic [frrb_pkg::LEN_W-1:0]    frame_length
);
	import frrb_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	frrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	frrb_datapath #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.rx_byte       (rx_byte),
		.sts           (sts),
		.result_strobe (result_strobe),
		.payload_byte  (payload_byte),
		.byte_valid    (byte_valid),
		.last          (last),
		.pop_status    (pop_status),
		.frame_length  (frame_length)
	);

endmodule

FILE: design/frrb_ctrl.sv
// Controller state machine for the framed receive ring buffer.
// Walks the ring on a pop and issues commands to frrb_datapath; depends on frrb_pkg.
module frrb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              operation,
	input  frrb_pkg::dp_sts_t sts,
	output frrb_pkg::dp_cmd_t cmd,
	output logic              busy
);
	import frrb_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SKIP_RD,
		S_SKIP_CHK,
		S_PAY_RD,
		S_PAY_CHK
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start && operation == OP_POP) begin
						state_q <= S_SKIP_RD;
					end
				end
				S_SKIP_RD: begin
					state_q <= sts.ptr_equal ? S_IDLE : S_SKIP_CHK;
				end
				S_SKIP_CHK: begin
					state_q <= sts.is_start ? S_PAY_RD : S_SKIP_RD;
				end
				S_PAY_RD: begin
					state_q <= sts.ptr_equal ? S_IDLE : S_PAY_CHK;
				end
				S_PAY_CHK: begin
					state_q <= sts.is_end ? S_IDLE : S_PAY_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.close_status = STATUS_NONE;
		case (state_q)
			S_IDLE: begin
				cmd.store = start && operation == OP_RX;
				cmd.clr_count = start && operation == OP_POP;
			end
			S_SKIP_RD: begin
				cmd.emit_close = sts.ptr_equal;
				cmd.close_status = STATUS_NONE;
			end
			S_SKIP_CHK: begin
				cmd.adv_rp = 1'b1;
			end
			S_PAY_RD: begin
				cmd.emit_close = sts.ptr_equal;
				cmd.close_status = STATUS_INCOMPLETE;
			end
			S_PAY_CHK: begin
				cmd.adv_rp = 1'b1;
				cmd.emit_byte = !sts.is_end;
				cmd.emit_close = sts.is_end;
				cmd.close_status = STATUS_COMPLETE;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	a_store_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> state_q == S_IDLE)
		else $error("store issued during a pop");

	a_empty_ends_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SKIP_RD || state_q == S_PAY_RD) && sts.ptr_equal |=> state_q == S_IDLE)
		else $error("pop did not end at the write pointer");

	a_single_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_byte && cmd.emit_close))
		else $error("payload and closing result issued together");

endmodule

FILE: design/frrb_datapath.sv
// Datapath for the framed receive ring buffer: ring memory, pointers, frame flag, count, outputs.
// Driven by frrb_ctrl commands; depends on frrb_pkg.
module frrb_datapath #(
	parameter int BUFFER_DEPTH = frrb_pkg::DEFAULT_BUFFER_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  frrb_pkg::dp_cmd_t                 cmd,
	input  logic [frrb_pkg::BYTE_W-1:0]       rx_byte,
	output frrb_pkg::dp_sts_t                 sts,
	output logic                              result_strobe,
	output logic [frrb_pkg::BYTE_W-1:0]       payload_byte,
	output logic                              byte_valid,
	output logic                              last,
	output logic [frrb_pkg::STATUS_W-1:0]     pop_status,
	output logic [frrb_pkg::LEN_W-1:0]        frame_length
);
	import frrb_pkg::*;

	localparam int PTR_W = $clog2(BUFFER_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);

	logic [BYTE_W-1:0] mem [BUFFER_DEPTH];
	logic [BYTE_W-1:0] rdata_q;
	logic [PTR_W-1:0]  wp_q;
	logic [PTR_W-1:0]  rp_q;
	logic              in_frame_q;
	logic [LEN_W-1:0]  count_q;
	logic              do_write;
	logic              strobe_q;
	logic [BYTE_W-1:0] byte_q;
	logic              valid_q;
	logic              last_q;
	logic [STATUS_W-1:0] status_q;
	logic [LEN_W-1:0]  len_q;

	assign do_write = cmd.store && (in_frame_q || rx_byte == START_MARK);

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[wp_q] <= rx_byte;
		end
		rdata_q <= mem[rp_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			in_frame_q <= 1'b0;
			count_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit_byte || cmd.emit_close;
			if (do_write) begin
				wp_q <= (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
				if (!in_frame_q) begin
					in_frame_q <= 1'b1;
				end else if (rx_byte == END_MARK) begin
					in_frame_q <= 1'b0;
				end
			end
			if (cmd.adv_rp) begin
				rp_q <= (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;
			end
			if (cmd.clr_count) begin
				count_q <= '0;
			end else if (cmd.emit_byte) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= cmd.emit_byte ? rdata_q : '0;
		valid_q <= cmd.emit_byte;
		last_q <= cmd.emit_close;
		status_q <= cmd.emit_close ? cmd.close_status : STATUS_NONE;
		len_q <= cmd.emit_close ? count_q : '0;
	end

	assign sts.ptr_equal = (rp_q == wp_q);
	assign sts.is_start = (rdata_q == START_MARK);
	assign sts.is_end = (rdata_q == END_MARK);

	assign result_strobe = strobe_q;
	assign payload_byte = byte_q;
	assign byte_valid = valid_q;
	assign last = last_q;
	assign pop_status = status_q;
	assign frame_length = len_q;

	a_wp_moves_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		!do_write |=> $stable(wp_q))
		else $error("write pointer moved without a store");

	a_emit_byte_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_byte |=> result_strobe && byte_valid && !last)
		else $error("payload transfer not presented");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for framed_receive_ring_buffer_top.
// Tracks the ring store, pointers and frame state to predict every pop result and checks each
// strobed result in order; depends on frrb_pkg and the RTL of the block.
module tb_top;
	import frrb_pkg::*;

	localparam int DEPTH = DEFAULT_BUFFER_DEPTH;

	typedef logic [BYTE_W-1:0] data_t;
	typedef logic [$clog2(DEPTH)-1:0] slot_t;

	typedef struct {
		data_t data;
		logic valid;
		logic closing;
		logic [STATUS_W-1:0] status;
		logic [LEN_W-1:0] length;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic operation = OP_RX;
	data_t rx_byte = '0;
	logic busy;
	logic result_strobe;
	data_t payload_byte;
	logic byte_valid;
	logic last;
	logic [STATUS_W-1:0] pop_status;
	logic [LEN_W-1:0] frame_length;

	data_t ring_copy [DEPTH];
	slot_t wr_slot = '0;
	slot_t rd_slot = '0;
	logic frame_open = 1'b0;
	frame_result_t expected_frame_results [$];

	int error_count = 0;
	int transfers_in = 0;
	int results_out = 0;
	int closes_by_status [3] = '{0, 0, 0};
	int sender_idle_pct = 0;

	framed_receive_ring_buffer_top #(.BUFFER_DEPTH(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.rx_byte(rx_byte),
		.result_strobe(result_strobe),
		.payload_byte(payload_byte),
		.byte_valid(byte_valid),
		.last(last),
		.pop_status(pop_status),
		.frame_length(frame_length)
	);

	always #1 clk = ~clk;

	initial begin
		#1_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

	function automatic slot_t next_slot(slot_t s);
		return slot_t'((int'(s) + 1) % DEPTH);
	endfunction

	function automatic void push_result(data_t d, logic v, logic c, logic [STATUS_W-1:0] st,
			int n);
		frame_result_t r;
		r.data = d;
		r.valid = v;
		r.closing = c;
		r.status = st;
		r.length = LEN_W'(n);
		expected_frame_results.push_back(r);
	endfunction

	// Updates the ring copy for one accepted transfer and queues the results it causes.
	function automatic void track_ring_item(logic op, data_t d);
		int count;
		count = 0;
		if (op == OP_RX) begin
			if (frame_open || d == START_MARK) begin
				ring_copy[wr_slot] = d;
				wr_slot = next_slot(wr_slot);
				frame_open = frame_open ? (d != END_MARK) : 1'b1;
			end
			return;
		end
		while (rd_slot != wr_slot && ring_copy[rd_slot] != START_MARK)
			rd_slot = next_slot(rd_slot);
		if (rd_slot == wr_slot) begin
			push_result('0, 1'b0, 1'b1, STATUS_NONE, 0);
			return;
		end
		rd_slot = next_slot(rd_slot);
		while (rd_slot != wr_slot && ring_copy[rd_slot] != END_MARK) begin
			push_result(ring_copy[rd_slot], 1'b1, 1'b0, STATUS_NONE, 0);
			count++;
			rd_slot = next_slot(rd_slot);
		end
		if (rd_slot == wr_slot) begin
			push_result('0, 1'b0, 1'b1, STATUS_INCOMPLETE, count);
		end else begin
			rd_slot = next_slot(rd_slot);
			push_result('0, 1'b0, 1'b1, STATUS_COMPLETE, count);
		end
	endfunction

	function automatic data_t random_payload_byte();
		data_t v;
		do v = data_t'($urandom_range(0, 255)); while (v == END_MARK);
		return v;
	endfunction

	task automatic send_item(logic op, data_t d);
		if (sender_idle_pct > 0) begin
			while ($urandom_range(0, 99) < sender_idle_pct) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		@(negedge clk);
		start <= 1'b1;
		operation <= op;
		rx_byte <= d;
		do @(posedge clk); while (busy);
		track_ring_item(op, d);
		transfers_in++;
	endtask

	task automatic send_pop();
		send_item(OP_POP, data_t'($urandom_range(0, 255)));
	endtask

	task automatic send_frame(int payload_len, bit terminate);
		send_item(OP_RX, START_MARK);
		repeat (payload_len) send_item(OP_RX, random_payload_byte());
		if (terminate)
			send_item(OP_RX, END_MARK);
	endtask

	// Holds the sender off until every expected result has been seen, or flags an error when the wait runs out.
	task automatic wait_for_results();
		int waited;
		waited = 0;
		@(negedge clk);
		start <= 1'b0;
		while (expected_frame_results.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		if (expected_frame_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_frame_results.size());
			error_count++;
		end
		repeat (6) @(posedge clk);
	endtask

	task automatic compare_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		frame_result_t exp_r;
		if (arst_n && result_strobe) begin
			results_out++;
			if (expected_frame_results.size() == 0) begin
				$error("Result with no expectation pending: payload_byte 0x%0h last %0b",
					payload_byte, last);
				error_count++;
			end else begin
				exp_r = expected_frame_results.pop_front();
				compare_field("payload_byte", exp_r.data, payload_byte);
				compare_field("byte_valid", exp_r.valid, byte_valid);
				compare_field("last", exp_r.closing, last);
				compare_field("pop_status", exp_r.status, pop_status);
				compare_field("frame_length", exp_r.length, frame_length);
				if (exp_r.closing && exp_r.status <= STATUS_INCOMPLETE)
					closes_by_status[exp_r.status]++;
			end
		end
	end

	task automatic test_empty_and_dropped();
		send_pop();
		send_item(OP_RX, 8'h00);
		send_item(OP_RX, 8'hFF);
		send_item(OP_RX, END_MARK);
		send_item(OP_RX, 8'h41);
		send_pop();
	endtask

	task automatic test_basic_frames();
		send_item(OP_RX, START_MARK);
		send_item(OP_RX, 8'h00);
		send_item(OP_RX, 8'hFF);
		send_item(OP_RX, 8'hAA);
		send_item(OP_RX, 8'h55);
		send_item(OP_RX, END_MARK);
		send_pop();
		send_frame(0, 1'b1);
		send_pop();
		send_item(OP_RX, START_MARK);
		send_item(OP_RX, START_MARK);
		send_item(OP_RX, 8'h62);
		send_item(OP_RX, END_MARK);
		send_pop();
		send_pop();
	endtask

	task automatic test_unterminated();
		send_frame(2, 1'b0);
		send_pop();
		send_item(OP_RX, END_MARK);
		send_pop();
	endtask

	task automatic test_long_and_overrun();
		send_frame(DEPTH - 2, 1'b0);
		send_pop();
		send_item(OP_RX, END_MARK);
		send_pop();
		send_frame(DEPTH - 3, 1'b1);
		send_pop();
		send_frame(DEPTH + 6, 1'b1);
		send_pop();
		send_frame(3, 1'b1);
		send_pop();
	endtask

	// Mostly well-formed frames with random content, mixed with noise, lone pops and frames
	// that are popped before their end mark arrives.
	task automatic test_random_traffic(int item_budget, int idle_pct);
		int stop_at;
		int pick;
		sender_idle_pct = idle_pct;
		stop_at = transfers_in + item_budget;
		while (transfers_in < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				repeat ($urandom_range(0, 1)) send_item(OP_RX, random_payload_byte());
				send_frame($urandom_range(0, 9), 1'b1);
				if ($urandom_range(0, 1))
					send_pop();
			end else if (pick < 80) begin
				send_pop();
			end else if (pick < 90) begin
				send_frame($urandom_range(0, 5), 1'b0);
				send_pop();
				send_item(OP_RX, END_MARK);
			end else begin
				send_item(OP_RX, data_t'($urandom_range(0, 255)));
			end
		end
		repeat (3) send_pop();
		wait_for_results();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_empty_and_dropped();
		test_basic_frames();
		test_unterminated();
		wait_for_results();
		test_long_and_overrun();
		wait_for_results();
		test_random_traffic(10, 32);
		test_random_traffic(10, 67);
		test_random_traffic(10, 0);

		$display("Sent %0d transfers and checked %0d results.", transfers_in, results_out);
		$display("Pops closed: %0d empty, %0d complete, %0d incomplete.",
			closes_by_status[0], closes_by_status[1], closes_by_status[2]);
		if (error_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

FILE: framed_receive_ring_buffer_top.f
design/frrb_pkg.sv
design/frrb_ctrl.sv
design/frrb_datapath.sv
design/framed_receive_ring_buffer_top.sv
tb/tb_top.sv
